### rtl/core/gmd_pkg.sv
// Shared constants, codes and controller/datapath types for the grid maze search block.
package gmd_pkg;

   // Default sizes handed to the top level parameters.
   localparam int MAX_ROWS_DEF    = 32;
   localparam int MAX_COLS_DEF    = 32;
   localparam int STACK_DEPTH_DEF = 128;

   // Field widths fixed by the item formats.
   localparam int CFG_W     = 6;
   localparam int REG_IDX_W = 1;
   localparam int CODE_W    = 2;
   localparam int CELL_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int OUT_POS_W = 5;
   localparam int DIR_W     = 2;

   // Configuration register indexes and reset values.
   localparam logic [REG_IDX_W-1:0] REG_ROWS = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_COLS = 1'b1;
   localparam logic [CFG_W-1:0]     ROWS_RESET = 6'd5;
   localparam logic [CFG_W-1:0]     COLS_RESET = 6'd5;

   // Cell kinds.
   localparam logic [CODE_W-1:0] CELL_WALL     = 2'd0;
   localparam logic [CODE_W-1:0] CELL_OPEN     = 2'd1;
   localparam logic [CODE_W-1:0] CELL_START    = 2'd2;
   localparam logic [CODE_W-1:0] CELL_TREASURE = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_FOUND     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_START  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_MISMATCH  = 2'd3;

   // Neighbour directions, visited in this order.
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

   typedef struct packed {
      logic                load;
      logic                eval;
      logic                search_init;
      logic                div_step;
      logic                push_start;
      logic                pop;
      logic                fetch;
      logic                cell_read;
      logic                mark;
      logic                nb_read;
      logic                nb_push;
      logic                finish;
      logic [STATUS_W-1:0] fin_status;
      logic [DIR_W-1:0]    dir;
   } gmd_cmd_type;

   typedef struct packed {
      logic              count_bad;
      logic              start_seen;
      logic              div_more;
      logic              stack_empty;
      logic              nb_in_range;
      logic              visited;
      logic [CODE_W-1:0] code;
   } gmd_stat_type;

endpackage

### rtl/core/gmd_if.sv
// Valid/ready channel interfaces for maze cells in and search results out.
interface gmd_req_if;
   import gmd_pkg::*;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] cell_code;
   logic              last_cell;

   modport source (output valid, output cell_code, output last_cell, input ready);
   modport sink (input valid, input cell_code, input last_cell, output ready);
endinterface

interface gmd_rsp_if;
   import gmd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [OUT_POS_W-1:0] treasure_row;
   logic [OUT_POS_W-1:0] treasure_col;
   logic                 stack_overflowed;

   modport source (output valid, output status, output treasure_row, output treasure_col,
                   output stack_overflowed, input ready);
   modport sink (input valid, input status, input treasure_row, input treasure_col,
                 input stack_overflowed, output ready);
endinterface

### rtl/core/gmd_datapath.sv
// Datapath: configuration, grid memory, search stack, position arithmetic and result register.
module gmd_datapath #(
   parameter int MAX_ROWS    = gmd_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS    = gmd_pkg::MAX_COLS_DEF,
   parameter int STACK_DEPTH = gmd_pkg::STACK_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gmd_pkg::gmd_cmd_type             cmd,
   output gmd_pkg::gmd_stat_type            stat,
   input  logic [gmd_pkg::CODE_W-1:0]       cell_code,
   input  logic                             csr_wr_en,
   input  logic [gmd_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [gmd_pkg::CFG_W-1:0]        csr_wr_data,
   output logic [gmd_pkg::STATUS_W-1:0]     rsp_status,
   output logic [gmd_pkg::OUT_POS_W-1:0]    rsp_row,
   output logic [gmd_pkg::OUT_POS_W-1:0]    rsp_col,
   output logic                             rsp_overflow
);
   import gmd_pkg::*;

   localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
   localparam int POS_W    = $clog2(CELL_CAP);
   localparam int LIDX_W   = $clog2(CELL_CAP + 2);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ENT_W    = ROW_W + COL_W;
   localparam int STK_AW   = $clog2(STACK_DEPTH);
   localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
   localparam int MUL_W    = POS_W + CFG_W;
   localparam int TOT_W    = 2 * CFG_W;

   // Configuration registers.
   logic [CFG_W-1:0] rows_ff, cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ROWS: rows_ff <= csr_wr_data;
            REG_COLS: cols_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Load bookkeeping.
   logic [LIDX_W-1:0] load_idx_ff, load_idx_in;
   logic [POS_W-1:0]  start_pos_ff;
   logic              start_seen_ff, start_seen_in;
   logic              in_cap;

   assign in_cap = load_idx_ff < LIDX_W'(CELL_CAP);

   always_comb begin
      load_idx_in   = load_idx_ff;
      start_seen_in = start_seen_ff;
      if (cmd.load) begin
         if (load_idx_ff <= LIDX_W'(CELL_CAP)) begin
            load_idx_in = load_idx_ff + LIDX_W'(1);
         end
         if (in_cap && cell_code == CELL_START) begin
            start_seen_in = 1'b1;
         end
      end else if (cmd.eval) begin
         load_idx_in   = '0;
         start_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_idx_ff   <= '0;
         start_seen_ff <= 1'b0;
      end else begin
         load_idx_ff   <= load_idx_in;
         start_seen_ff <= start_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && in_cap && cell_code == CELL_START) begin
         start_pos_ff <= load_idx_ff[POS_W-1:0];
      end
   end

   // Count and register checks for the maze just loaded.
   logic             cfg_ok;
   logic [TOT_W-1:0] cell_total;

   assign cfg_ok = rows_ff != '0 && cols_ff != '0 &&
                   32'(rows_ff) <= MAX_ROWS && 32'(cols_ff) <= MAX_COLS;
   assign cell_total = TOT_W'(rows_ff) * TOT_W'(cols_ff);

   // Start position to row and column by repeated subtraction of the row length.
   logic [POS_W-1:0] rem_ff;
   logic [ROW_W-1:0] div_row_ff;

   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         rem_ff     <= start_pos_ff;
         div_row_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= rem_ff - POS_W'(cols_ff);
         div_row_ff <= div_row_ff + ROW_W'(1);
      end
   end

   // Current cell and neighbour arithmetic.
   logic [ROW_W-1:0] cur_row_ff, nb_row;
   logic [COL_W-1:0] cur_col_ff, nb_col;
   logic [POS_W-1:0] pos_ff, nb_pos;
   logic [ENT_W-1:0] nb_ent_ff, stk_rd_ff;
   logic             nb_in_range;

   always_comb begin
      nb_in_range = 1'b0;
      nb_pos      = pos_ff;
      nb_row      = cur_row_ff;
      nb_col      = cur_col_ff;
      case (cmd.dir)
         DIR_UP: begin
            nb_in_range = cur_row_ff != '0;
            nb_pos      = pos_ff - POS_W'(cols_ff);
            nb_row      = cur_row_ff - ROW_W'(1);
         end
         DIR_DOWN: begin
            nb_in_range = 32'(cur_row_ff) + 32'd1 < 32'(rows_ff);
            nb_pos      = pos_ff + POS_W'(cols_ff);
            nb_row      = cur_row_ff + ROW_W'(1);
         end
         DIR_LEFT: begin
            nb_in_range = cur_col_ff != '0;
            nb_pos      = pos_ff - POS_W'(1);
            nb_col      = cur_col_ff - COL_W'(1);
         end
         DIR_RIGHT: begin
            nb_in_range = 32'(cur_col_ff) + 32'd1 < 32'(cols_ff);
            nb_pos      = pos_ff + POS_W'(1);
            nb_col      = cur_col_ff + COL_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         cur_row_ff <= stk_rd_ff[ENT_W-1:COL_W];
         cur_col_ff <= stk_rd_ff[COL_W-1:0];
         pos_ff     <= POS_W'(MUL_W'(stk_rd_ff[ENT_W-1:COL_W]) * MUL_W'(cols_ff) +
                              MUL_W'(stk_rd_ff[COL_W-1:0]));
      end
      if (cmd.nb_read) begin
         nb_ent_ff <= {nb_row, nb_col};
      end
   end

   // Grid memory: cell code with the visited flag on top.
   logic [CELL_W-1:0] grid_mem [CELL_CAP];
   logic [CELL_W-1:0] grid_rd_ff;
   logic [POS_W-1:0]  grid_rd_addr;

   assign grid_rd_addr = cmd.nb_read ? nb_pos : pos_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && in_cap) begin
         grid_mem[load_idx_ff[POS_W-1:0]] <= {1'b0, cell_code};
      end else if (cmd.mark) begin
         grid_mem[pos_ff] <= {1'b1, grid_rd_ff[CODE_W-1:0]};
      end
      if (cmd.cell_read || cmd.nb_read) begin
         grid_rd_ff <= grid_mem[grid_rd_addr];
      end
   end

   // Search stack of row and column pairs.
   logic [ENT_W-1:0] stack_mem [STACK_DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in, pop_idx;
   logic             overflow_ff, overflow_in;
   logic             push_req, full;
   logic [ENT_W-1:0] push_ent;

   assign push_req = cmd.push_start || cmd.nb_push;
   assign push_ent = cmd.push_start ? {div_row_ff, COL_W'(rem_ff)} : nb_ent_ff;
   assign full     = cnt_ff == CNT_W'(STACK_DEPTH);
   assign pop_idx  = cnt_ff - CNT_W'(1);

   always_comb begin
      cnt_in      = cnt_ff;
      overflow_in = overflow_ff;
      if (cmd.search_init) begin
         cnt_in      = '0;
         overflow_in = 1'b0;
      end else if (push_req) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end else if (cmd.pop) begin
         cnt_in = pop_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         overflow_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_req && !full) begin
         stack_mem[cnt_ff[STK_AW-1:0]] <= push_ent;
      end
      if (cmd.pop) begin
         stk_rd_ff <= stack_mem[pop_idx[STK_AW-1:0]];
      end
   end

   // Result register.
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [OUT_POS_W-1:0] rsp_row_ff, rsp_col_ff;
   logic                 rsp_overflow_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff   <= cmd.fin_status;
         rsp_row_ff      <= (cmd.fin_status == STAT_FOUND) ? OUT_POS_W'(cur_row_ff) : '0;
         rsp_col_ff      <= (cmd.fin_status == STAT_FOUND) ? OUT_POS_W'(cur_col_ff) : '0;
         rsp_overflow_ff <= overflow_ff && (cmd.fin_status == STAT_FOUND ||
                                            cmd.fin_status == STAT_NOT_FOUND);
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_row      = rsp_row_ff;
   assign rsp_col      = rsp_col_ff;
   assign rsp_overflow = rsp_overflow_ff;

   always_comb begin
      stat             = '0;
      stat.count_bad   = !(cfg_ok && 32'(load_idx_ff) == 32'(cell_total));
      stat.start_seen  = start_seen_ff;
      stat.div_more    = 32'(rem_ff) >= 32'(cols_ff);
      stat.stack_empty = cnt_ff == '0;
      stat.nb_in_range = nb_in_range;
      stat.visited     = grid_rd_ff[CELL_W-1];
      stat.code        = grid_rd_ff[CODE_W-1:0];
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond stack depth");

   a_drop_flags: assert property (@(posedge clock) disable iff (reset)
      (push_req && full && !cmd.search_init) |=> overflow_ff)
      else $error("dropped push did not set the overflow flag");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> cnt_ff != '0)
      else $error("pop issued on an empty stack");

endmodule

### rtl/core/gmd_ctrl.sv
// Controller: sequences loading, checks, the depth-first search and the result handshake.
module gmd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gmd_pkg::gmd_cmd_type  cmd,
   input  gmd_pkg::gmd_stat_type stat
);
   import gmd_pkg::*;

   typedef enum logic [8:0] {
      ST_LOAD       = 9'b000000001,
      ST_EVAL       = 9'b000000010,
      ST_DIVIDE     = 9'b000000100,
      ST_POP        = 9'b000001000,
      ST_FETCH      = 9'b000010000,
      ST_CELL_RD    = 9'b000100000,
      ST_CELL_CHECK = 9'b001000000,
      ST_NB_SEL     = 9'b010000000,
      ST_NB_CHECK   = 9'b100000000
   } gmd_state_type;

   gmd_state_type    state_ff, state_in;
   logic [DIR_W-1:0] dir_ff, dir_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // A last cell is held off while an earlier result still waits.
   assign req_ready = (state_ff == ST_LOAD) && (!rsp_valid_ff || !req_last);

   always_comb begin
      state_in = state_ff;
      dir_in   = dir_ff;
      cmd      = '0;
      cmd.dir  = dir_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (stat.count_bad) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = STAT_MISMATCH;
               state_in       = ST_LOAD;
            end else if (!stat.start_seen) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = STAT_NO_START;
               state_in       = ST_LOAD;
            end else begin
               cmd.search_init = 1'b1;
               state_in        = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (stat.div_more) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.push_start = 1'b1;
               state_in       = ST_POP;
            end
         end
         ST_POP: begin
            if (stat.stack_empty) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = STAT_NOT_FOUND;
               state_in       = ST_LOAD;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_CELL_RD;
         end
         ST_CELL_RD: begin
            cmd.cell_read = 1'b1;
            state_in      = ST_CELL_CHECK;
         end
         ST_CELL_CHECK: begin
            if (stat.code == CELL_TREASURE) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = STAT_FOUND;
               state_in       = ST_LOAD;
            end else begin
               // The start cell stays unvisited and may be pushed again.
               cmd.mark = stat.code != CELL_START;
               dir_in   = DIR_UP;
               state_in = ST_NB_SEL;
            end
         end
         ST_NB_SEL: begin
            if (stat.nb_in_range) begin
               cmd.nb_read = 1'b1;
               state_in    = ST_NB_CHECK;
            end else if (dir_ff == DIR_RIGHT) begin
               state_in = ST_POP;
            end else begin
               dir_in = dir_ff + DIR_W'(1);
            end
         end
         ST_NB_CHECK: begin
            cmd.nb_push = stat.code != CELL_WALL && !stat.visited;
            if (dir_ff == DIR_RIGHT) begin
               state_in = ST_POP;
            end else begin
               dir_in   = dir_ff + DIR_W'(1);
               state_in = ST_NB_SEL;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         dir_ff       <= DIR_UP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid_ff)
      else $error("result finished while an earlier one still waits");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_push_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.nb_push |-> $past(cmd.nb_read))
      else $error("neighbour pushed without a preceding grid read");

endmodule

### rtl/core/grid_maze_dfs_solver.sv
// Top level of the grid maze depth-first search block.
// Usage: set rows and columns through the csr write port (index 0 rows, index 1 columns,
// both 5 after reset), then send the cells of one maze in row-major order on req_ch, one
// item per cell, with last_cell high on the final one. Cells are taken one per cycle while
// no search runs. Every item but the last produces nothing; the last one produces exactly
// one item on rsp_ch: status, treasure row and column, and the stack overflow flag.
// After the last cell, req_ch.ready stays low while the search runs, and the result is valid
// from the cycle after the search ends. A bad cell count or a missing start ends it at the
// check. A search checks the count and the start, turns the start position into a row and
// column by one subtraction of the row length per row above the start (at most MAX_ROWS - 1),
// pushes the start, then pops, fetches and reads each cell and, unless that cell holds the
// treasure, reads each in-range neighbour and pushes it if it is no wall and unvisited; a
// search that empties its stack ends when it finds the stack empty.
// The result stays in an output register until rsp_ch.ready; loading of the next maze
// goes on meanwhile, and only its last cell waits for the register to empty.
// Reset (synchronous, active high) empties the result register, the stack and the load
// count and returns both size registers to 5. The grid memory needs no clearing.
module grid_maze_dfs_solver #(
   parameter int MAX_ROWS    = gmd_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS    = gmd_pkg::MAX_COLS_DEF,
   parameter int STACK_DEPTH = gmd_pkg::STACK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   gmd_req_if.sink                       req_ch,
   gmd_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [gmd_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [gmd_pkg::CFG_W-1:0]     csr_wr_data
);
   import gmd_pkg::*;

   gmd_cmd_type  cmd;
   gmd_stat_type stat;

   gmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_cell),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   gmd_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .cell_code    (req_ch.cell_code),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .rsp_status   (rsp_ch.status),
      .rsp_row      (rsp_ch.treasure_row),
      .rsp_col      (rsp_ch.treasure_col),
      .rsp_overflow (rsp_ch.stack_overflowed)
   );

endmodule

### bench/testbench.sv
// Self-checking testbench for the grid maze depth-first search block.
`timescale 1ns / 100ps

module testbench;
   import gmd_pkg::*;

   localparam int unsigned CELL_CAP      = MAX_ROWS_DEF * MAX_COLS_DEF;
   localparam int unsigned RANDOM_CELLS  = 880;
   localparam int unsigned LONG_HOLD     = 600;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT   = 3_000_000;
   localparam int unsigned REPORT_MAX    = 10;
   localparam int unsigned HOLD_AT [2]   = '{10, 25};

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              last;
   } cell_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [OUT_POS_W-1:0] row;
      logic [OUT_POS_W-1:0] col;
      logic                 overflow;
   } verdict_type;

   typedef logic [CODE_W-1:0] code_list_type [$];

   typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_SPARSE} ready_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [REG_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wr_data;

   gmd_req_if req_ch ();
   gmd_rsp_if rsp_ch ();

   grid_maze_dfs_solver u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   cell_item_type cell_q [$];
   verdict_type   verdict_q [$];

   // Mirror of the maze store, the search stack and the load state.
   logic [CELL_W-1:0] maze_mem [CELL_CAP];
   logic [9:0]        dfs_stack [STACK_DEPTH_DEF];
   int unsigned       dfs_depth;
   int unsigned       load_idx;
   int unsigned       start_pos;
   bit                start_found;
   bit                dropped_push;
   int unsigned       rows_cfg = ROWS_RESET;
   int unsigned       cols_cfg = COLS_RESET;

   bit             cell_held;
   int unsigned    results_seen;
   int unsigned    error_count;
   int unsigned    cycle_count;
   int unsigned    burst_left;
   int unsigned    gap_left;
   int unsigned    hold_left;
   int unsigned    next_hold;
   int unsigned    mode_left;
   ready_mode_type ready_mode;
   verdict_type    want;

   function automatic void push_pos(int unsigned pos);
      if (dfs_depth < STACK_DEPTH_DEF) begin
         dfs_stack[dfs_depth] = pos[9:0];
         dfs_depth++;
      end else begin
         dropped_push = 1'b1;
      end
   endfunction

   function automatic void push_if_open(int unsigned pos);
      logic [CELL_W-1:0] slot;
      slot = maze_mem[pos % CELL_CAP];
      if (slot[CODE_W-1:0] != CELL_WALL && !slot[CELL_W-1]) push_pos(pos);
   endfunction

   function automatic bit find_treasure(int unsigned rows, int unsigned cols,
                                        output int unsigned where);
      int unsigned       pos;
      int unsigned       r;
      int unsigned       c;
      logic [CODE_W-1:0] code;
      where = 0;
      dfs_depth = 0;
      dropped_push = 1'b0;
      push_pos(start_pos);
      while (dfs_depth > 0) begin
         dfs_depth--;
         pos = dfs_stack[dfs_depth];
         code = maze_mem[pos][CODE_W-1:0];
         if (code == CELL_TREASURE) begin
            where = pos;
            return 1'b1;
         end
         // The start cell is never marked, so it can be pushed again.
         if (code != CELL_START) maze_mem[pos][CELL_W-1] = 1'b1;
         r = pos / cols;
         c = pos % cols;
         if (r > 0) push_if_open(pos - cols);
         if (r + 1 < rows) push_if_open(pos + cols);
         if (c > 0) push_if_open(pos - 1);
         if (c + 1 < cols) push_if_open(pos + 1);
      end
      return 1'b0;
   endfunction

   function automatic void take_cell(logic [CODE_W-1:0] code, logic last);
      verdict_type v;
      int unsigned where;
      if (load_idx < CELL_CAP) begin
         maze_mem[load_idx] = {1'b0, code};
         if (code == CELL_START) begin
            start_pos = load_idx;
            start_found = 1'b1;
         end
      end
      // The count saturates one past capacity so that excess cells still mismatch.
      if (load_idx <= CELL_CAP) load_idx++;
      if (last) begin
         v = '0;
         if (rows_cfg == 0 || cols_cfg == 0 || rows_cfg > MAX_ROWS_DEF ||
             cols_cfg > MAX_COLS_DEF || load_idx != rows_cfg * cols_cfg) begin
            v.status = STAT_MISMATCH;
         end else if (!start_found) begin
            v.status = STAT_NO_START;
         end else if (find_treasure(rows_cfg, cols_cfg, where)) begin
            v.status = STAT_FOUND;
            v.row = OUT_POS_W'(where / cols_cfg);
            v.col = OUT_POS_W'(where % cols_cfg);
            v.overflow = dropped_push;
         end else begin
            v.status = STAT_NOT_FOUND;
            v.overflow = dropped_push;
         end
         load_idx = 0;
         start_found = 1'b0;
         verdict_q.push_back(v);
      end
   endfunction

   function automatic void flag_error(string what);
      error_count++;
      if (error_count <= REPORT_MAX) $display("%s", what);
   endfunction

   initial begin
      clock = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.cell_code = CELL_WALL;
      req_ch.last_cell = 1'b0;
      rsp_ch.ready = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[grid_maze_dfs_solver] ERROR");
         $finish;
      end
   end

   // Cell sender: bursts of items with random gaps, holding an item until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!cell_held) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (cell_q.size() != 0) begin
            req_ch.valid <= 1'b1;
            req_ch.cell_code <= cell_q[0].code;
            req_ch.last_cell <= cell_q[0].last;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Long hold-off of the receiver, started while a result waits and cells are still
   // pending, so that the next last cell is held off at the input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
      end else if (next_hold < 2 && results_seen >= HOLD_AT[next_hold] &&
                   rsp_ch.valid && cell_q.size() != 0) begin
         hold_left = LONG_HOLD;
         next_hold++;
      end
   end

   // Result receiver: changing stall patterns, and no ready during a long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            RDY_ALWAYS: rsp_ch.ready <= 1'b1;
            RDY_HALF:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            default:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         cell_held = 1'b0;
      end else begin
         cell_held = req_ch.valid && !req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            take_cell(req_ch.cell_code, req_ch.last_cell);
            void'(cell_q.pop_front());
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
               flag_error($sformatf("result %0d arrived with none expected: status %0d",
                                    results_seen, rsp_ch.status));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.treasure_row !== want.row ||
                   rsp_ch.treasure_col !== want.col ||
                   rsp_ch.stack_overflowed !== want.overflow) begin
                  flag_error($sformatf({"result %0d mismatch (expected/actual): status %0d/%0d",
                                        " row %0d/%0d col %0d/%0d overflow %0d/%0d"},
                                       results_seen, want.status, rsp_ch.status,
                                       want.row, rsp_ch.treasure_row,
                                       want.col, rsp_ch.treasure_col,
                                       want.overflow, rsp_ch.stack_overflowed));
               end
            end
         end
      end
   end

   task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= CFG_W'(value);
      if (idx == REG_ROWS) rows_cfg = value;
      else cols_cfg = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_size(int unsigned rows, int unsigned cols);
      write_reg(REG_ROWS, rows);
      write_reg(REG_COLS, cols);
   endtask

   // Returns once every cell is taken and every result is in, so the block is idle.
   task automatic wait_idle();
      while (cell_q.size() != 0 || verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void queue_cells(code_list_type codes);
      foreach (codes[i]) cell_q.push_back(cell_item_type'{code: codes[i],
                                                          last: (i == codes.size() - 1)});
   endfunction

   function automatic void queue_maze(int unsigned count, int unsigned cols);
      code_list_type codes;
      int unsigned   wall_pct;
      int unsigned   treasures;
      int unsigned   starts;
      bit            noisy;
      noisy = ($urandom_range(0, 9) == 0);
      wall_pct = $urandom_range(0, 45);
      for (int unsigned i = 0; i < count; i++) begin
         if (noisy) codes.push_back(CODE_W'($urandom_range(0, 3)));
         else codes.push_back(($urandom_range(0, 99) < wall_pct) ? CELL_WALL : CELL_OPEN);
      end
      treasures = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2);
      repeat (treasures) codes[$urandom_range(0, count - 1)] = CELL_TREASURE;
      case ($urandom_range(0, 9))
         0:       starts = 0;
         1:       starts = 2;
         default: starts = 1;
      endcase
      repeat (starts) codes[$urandom_range(0, count - 1)] = CELL_START;
      // Two adjacent start cells would bounce between each other for ever.
      if (cols != 0) begin
         for (int unsigned i = 0; i < count; i++) begin
            if (codes[i] == CELL_START &&
                ((i >= cols && codes[i - cols] == CELL_START) ||
                 (i % cols != 0 && codes[i - 1] == CELL_START)))
               codes[i] = CELL_OPEN;
         end
      end
      queue_cells(codes);
   endfunction

   int unsigned random_cells;
   int unsigned rows_pick;
   int unsigned cols_pick;
   int unsigned swap_tmp;
   int unsigned cells_in_maze;
   int unsigned size_kind;
   bit          bad_size;

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = REG_ROWS;
      csr_wr_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset sizes are 5 by 5, so three cells fail the count check.
      queue_cells('{CELL_OPEN, CELL_OPEN, CELL_TREASURE});
      wait_idle();
      set_size(1, 1);
      queue_cells('{CELL_START});
      queue_cells('{CELL_TREASURE});
      queue_cells('{CELL_WALL});
      wait_idle();
      set_size(1, 4);
      // The later of two starts wins and reaches the treasure on its left.
      queue_cells('{CELL_START, CELL_OPEN, CELL_TREASURE, CELL_START});
      queue_cells('{CELL_TREASURE, CELL_OPEN, CELL_WALL, CELL_START});
      queue_cells('{CELL_OPEN, CELL_START, CELL_OPEN, CELL_OPEN, CELL_OPEN});
      wait_idle();
      set_size(2, 1);
      queue_cells('{CELL_START, CELL_TREASURE});
      wait_idle();
      set_size(1, 0);
      queue_cells('{CELL_START});
      wait_idle();

      while (random_cells < RANDOM_CELLS) begin
         size_kind = $urandom_range(0, 99);
         bad_size = 1'b0;
         if (size_kind < 65) begin
            rows_pick = $urandom_range(1, 8);
            cols_pick = $urandom_range(1, 8);
         end else if (size_kind < 82) begin
            rows_pick = $urandom_range(1, 32);
            cols_pick = $urandom_range(1, (160 / rows_pick > 32) ? 32 : 160 / rows_pick);
         end else if (size_kind < 92) begin
            rows_pick = MAX_ROWS_DEF;
            cols_pick = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(2, 3);
         end else begin
            bad_size = 1'b1;
            rows_pick = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 63);
            cols_pick = $urandom_range(0, 63);
         end
         if ($urandom_range(0, 1) == 1) begin
            swap_tmp = rows_pick;
            rows_pick = cols_pick;
            cols_pick = swap_tmp;
         end
         set_size(rows_pick, cols_pick);
         repeat ($urandom_range(2, 6)) begin
            cells_in_maze = rows_pick * cols_pick;
            if (bad_size) begin
               cells_in_maze = $urandom_range(1, 40);
            end else if ($urandom_range(0, 7) == 0) begin
               cells_in_maze = cells_in_maze + $urandom_range(1, 3);
               if ($urandom_range(0, 1) == 0)
                  cells_in_maze = (cells_in_maze > 4) ? cells_in_maze - 4 : 1;
            end
            queue_maze(cells_in_maze, cols_pick);
            random_cells += cells_in_maze;
         end
         wait_idle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && verdict_q.size() == 0) begin
         $display("[grid_maze_dfs_solver] OK");
      end else begin
         $display("[grid_maze_dfs_solver] ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/gmd_pkg.sv
rtl/core/gmd_if.sv
rtl/core/gmd_datapath.sv
rtl/core/gmd_ctrl.sv
rtl/core/grid_maze_dfs_solver.sv
bench/testbench.sv
